// ===== sv/keyed_message_table_with_expiry_unit_defines.svh =====
// Assertion macros for the keyed message table unit.
// Included by the top level; depends on nothing else.
`ifndef KEYED_MESSAGE_TABLE_WITH_EXPIRY_UNIT_DEFINES_SVH
`define KEYED_MESSAGE_TABLE_WITH_EXPIRY_UNIT_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define KMT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/kmt_pkg.sv =====
// Shared types and constants of the keyed message table unit.
// Depends on nothing.
`timescale 1ns / 1ps
package kmt_pkg;
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [9:0] DEFAULT_VALIDITY_S = 10'd600;
  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    CMD_RECEIVE = 2'd0,
    CMD_DROP    = 2'd1,
    CMD_COUNT   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_OLDER    = 3'd2,
    ST_FULL     = 3'd3,
    ST_DROPPED  = 3'd4,
    ST_COUNTED  = 3'd5
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] station;
    logic [15:0] sequence_no;
    logic [41:0] reference;
    logic [42:0] expiry;
    logic [7:0]  cause;
    logic [41:0] now;
  } word_t;
endpackage

// ===== sv/kmt_front.sv =====
// Front end: accepts commands, computes the expiry, queues words.
// Depends on kmt_pkg.
`timescale 1ns / 1ps
module kmt_front import kmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_station_id,
  input  logic [15:0] in_sequence_number,
  input  logic [41:0] in_reference_time,
  input  logic [41:0] in_detection_time,
  input  logic        in_validity_present,
  input  logic [16:0] in_validity_seconds,
  input  logic [7:0]  in_cause_code,
  input  logic [41:0] in_current_time,
  output logic        q_valid,
  output word_t       q_word,
  input  logic        q_pop
);
  word_t       q_mem_r [QUEUE_DEPTH];
  logic [1:0]  q_cnt_r, q_cnt_nxt;
  logic        rd_r, wr_r;
  logic        push;
  logic [16:0] secs;
  logic [26:0] prod;
  word_t       w;

  assign secs = in_validity_present ? in_validity_seconds : {7'd0, DEFAULT_VALIDITY_S};
  assign prod = secs * {17'd0, MS_PER_S};
  always_comb begin
    w.cmd = cmd_t'(in_command);
    w.station = in_station_id;
    w.sequence_no = in_sequence_number;
    w.reference = in_reference_time;
    w.expiry = {1'b0, in_detection_time} + {16'd0, prod};
    w.cause = in_cause_code;
    w.now = in_current_time;
  end

  assign busy = (q_cnt_r == 2'(QUEUE_DEPTH));
  assign push = start && !busy && (in_command <= 2'(CMD_COUNT));
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_word = q_mem_r[rd_r];

  always_comb begin
    q_cnt_nxt = q_cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_r] <= w;
  end
endmodule

// ===== sv/kmt_back.sv =====
// Back end: scans the table slot by slot and carries out each word.
// Depends on kmt_pkg.
`timescale 1ns / 1ps
module kmt_back import kmt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  word_t            q_word,
  output logic             q_pop,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [CNT_W-1:0] out_entry_count
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  word_t             cur_r;
  logic [IDX_W-1:0]  idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [31:0]       st_r  [TABLE_ENTRIES];
  logic [15:0]       sq_r  [TABLE_ENTRIES];
  logic [41:0]       ref_r [TABLE_ENTRIES];
  logic [42:0]       exp_r [TABLE_ENTRIES];
  logic [7:0]        cc_r  [TABLE_ENTRIES];
  logic              found_r, free_r;
  logic [IDX_W-1:0]  found_idx_r, free_idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              last, v, hit;
  logic              do_write;
  logic [IDX_W-1:0]  wr_idx;
  logic [2:0]        status_nxt;
  logic              strobe_r;
  logic [2:0]        status_r;
  logic [CNT_W-1:0]  ocnt_r;

  assign last = (idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign v = valid_r[idx_r];
  always_comb begin
    hit = 1'b0;
    unique case (cur_r.cmd)
      CMD_RECEIVE: hit = v && st_r[idx_r] == cur_r.station && sq_r[idx_r] == cur_r.sequence_no;
      CMD_DROP:    hit = v && exp_r[idx_r] < {1'b0, cur_r.now};
      CMD_COUNT:   hit = v && cc_r[idx_r] == cur_r.cause;
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    do_write = 1'b0;
    wr_idx = free_idx_r;
    status_nxt = 3'(ST_COUNTED);
    priority if (cur_r.cmd == CMD_RECEIVE) begin
      if (found_r) begin
        wr_idx = found_idx_r;
        if (ref_r[found_idx_r] < cur_r.reference) begin
          do_write = 1'b1;
          status_nxt = 3'(ST_REPLACED);
        end else begin
          status_nxt = 3'(ST_OLDER);
        end
      end else if (free_r) begin
        do_write = 1'b1;
        status_nxt = 3'(ST_INSERTED);
      end else begin
        status_nxt = 3'(ST_FULL);
      end
    end else if (cur_r.cmd == CMD_DROP) begin
      status_nxt = 3'(ST_DROPPED);
    end else begin
      status_nxt = 3'(ST_COUNTED);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_SCAN;
      S_SCAN:  if (last) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_entry_count = ocnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      strobe_r <= (state_r == S_DONE);
      if (state_r == S_SCAN && cur_r.cmd == CMD_DROP && hit) valid_r[idx_r] <= 1'b0;
      if (state_r == S_DONE && do_write) valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_word;
      idx_r <= '0;
      found_r <= 1'b0;
      free_r <= 1'b0;
      cnt_r <= '0;
      found_idx_r <= '0;
      free_idx_r <= '0;
    end else if (state_r == S_SCAN) begin
      idx_r <= last ? idx_r : idx_r + 1'b1;
      if (hit && cur_r.cmd == CMD_RECEIVE && !found_r) begin
        found_r <= 1'b1;
        found_idx_r <= idx_r;
      end
      if (!v && !free_r) begin
        free_r <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (hit && cnt_r != COUNT_MAX) cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == S_DONE) begin
      status_r <= status_nxt;
      ocnt_r <= (cur_r.cmd == CMD_RECEIVE) ? '0 : cnt_r;
      if (do_write) begin
        st_r[wr_idx] <= cur_r.station;
        sq_r[wr_idx] <= cur_r.sequence_no;
        ref_r[wr_idx] <= cur_r.reference;
        exp_r[wr_idx] <= cur_r.expiry;
        cc_r[wr_idx] <= cur_r.cause;
      end
    end
  end
endmodule

// ===== sv/keyed_message_table_with_expiry_unit.sv =====
// Keyed message table with newest-replace and expiry purge, top level.
// From the accepting start edge, a command passes a queue hop, a 16-slot scan in
// the back end and an update step whose result is registered onto the outputs
// before out_strobe rises. Each command holds the back end for the whole slot
// scan; a two-word queue lets start be taken while a command
// runs. The receiver cannot stall.
// Synchronous active-low reset clears the queue, control state and valid bits.
`timescale 1ns / 1ps
`include "keyed_message_table_with_expiry_unit_defines.svh"
module keyed_message_table_with_expiry_unit import kmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_station_id,
  input  logic [15:0] in_sequence_number,
  input  logic [41:0] in_reference_time,
  input  logic [41:0] in_detection_time,
  input  logic        in_validity_present,
  input  logic [16:0] in_validity_seconds,
  input  logic [7:0]  in_cause_code,
  input  logic [41:0] in_current_time,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [4:0]  out_entry_count
);
  logic  q_valid, q_pop;
  word_t q_word;

  kmt_front u_front (
    .clk, .rst_n, .start, .busy, .in_command, .in_station_id, .in_sequence_number,
    .in_reference_time, .in_detection_time, .in_validity_present,
    .in_validity_seconds, .in_cause_code, .in_current_time,
    .q_valid, .q_word, .q_pop
  );

  kmt_back u_back (
    .clk, .rst_n, .q_valid, .q_word, .q_pop, .out_strobe, .out_status, .out_entry_count
  );

  `KMT_ASSERT_IMPL(a_pop_needs_word, clk, rst_n, q_pop, q_valid)
  `KMT_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)
  `KMT_ASSERT_IMPL(a_receive_count_zero, clk, rst_n,
    out_strobe && out_status <= 3'(ST_FULL), out_entry_count == 5'd0)
endmodule

// ===== test/keyed_message_table_with_expiry_unit_test.sv =====
// Self-checking testbench for the keyed message table with expiry unit.
// Drives receive, drop and count commands, predicts each result word from a
// local copy of the table, and compares it. Depends on kmt_pkg and the unit.
`timescale 1ns / 1ps
module keyed_message_table_with_expiry_unit_test;
  import kmt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [31:0] in_station_id = '0;
  logic [15:0] in_sequence_number = '0;
  logic [41:0] in_reference_time = '0;
  logic [41:0] in_detection_time = '0;
  logic        in_validity_present = 1'b0;
  logic [16:0] in_validity_seconds = '0;
  logic [7:0]  in_cause_code = '0;
  logic [41:0] in_current_time = '0;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [4:0]  out_entry_count;

  typedef struct {
    status_t    status;
    logic [4:0] count;
  } outcome_t;

  outcome_t   pending_outcomes[$];
  int         mismatches = 0;
  bit         idle_allowed = 1'b1;

  bit          tbl_valid[TABLE_ENTRIES];
  logic [31:0] tbl_station[TABLE_ENTRIES];
  logic [15:0] tbl_sequence[TABLE_ENTRIES];
  logic [41:0] tbl_reference[TABLE_ENTRIES];
  logic [42:0] tbl_expiry[TABLE_ENTRIES];
  logic [7:0]  tbl_cause[TABLE_ENTRIES];

  logic [31:0] key_stations[8];

  keyed_message_table_with_expiry_unit dut (.*);

  always #2 clk = ~clk;

  function automatic logic [4:0] saturate_count(int n);
    return (n > int'(COUNT_MAX)) ? COUNT_MAX : n[4:0];
  endfunction

  function automatic logic [41:0] rand42();
    return 42'({$urandom, $urandom});
  endfunction

  task automatic predict_table(input logic [1:0] cmd, input logic [31:0] st,
      input logic [15:0] sq, input logic [41:0] ref_t, input logic [41:0] det,
      input logic vp, input logic [16:0] vs, input logic [7:0] cc,
      input logic [41:0] now);
    int found;
    int free_slot;
    int n;
    logic [42:0] expiry;
    outcome_t o;
    found = -1;
    free_slot = -1;
    n = 0;
    o.count = '0;
    expiry = {1'b0, det} + (vp ? 43'(vs) : 43'(DEFAULT_VALIDITY_S)) * 43'd1000;
    if (cmd == CMD_RECEIVE) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tbl_valid[i]) begin
          if (found < 0 && tbl_station[i] == st && tbl_sequence[i] == sq) found = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (found >= 0) begin
        if (tbl_reference[found] < ref_t) begin
          tbl_reference[found] = ref_t;
          tbl_expiry[found] = expiry;
          tbl_cause[found] = cc;
          o.status = ST_REPLACED;
        end else begin
          o.status = ST_OLDER;
        end
      end else if (free_slot >= 0) begin
        tbl_valid[free_slot] = 1'b1;
        tbl_station[free_slot] = st;
        tbl_sequence[free_slot] = sq;
        tbl_reference[free_slot] = ref_t;
        tbl_expiry[free_slot] = expiry;
        tbl_cause[free_slot] = cc;
        o.status = ST_INSERTED;
      end else begin
        o.status = ST_FULL;
      end
    end else if (cmd == CMD_DROP) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_expiry[i] < {1'b0, now}) begin
          tbl_valid[i] = 1'b0;
          n++;
        end
      end
      o.status = ST_DROPPED;
      o.count = saturate_count(n);
    end else if (cmd == CMD_COUNT) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_cause[i] == cc) n++;
      end
      o.status = ST_COUNTED;
      o.count = saturate_count(n);
    end else begin
      return;
    end
    pending_outcomes.push_back(o);
  endtask

  task automatic send_word(input logic [1:0] cmd, input logic [31:0] st,
      input logic [15:0] sq, input logic [41:0] ref_t, input logic [41:0] det,
      input logic vp, input logic [16:0] vs, input logic [7:0] cc,
      input logic [41:0] now);
    while (idle_allowed && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_station_id <= st;
    in_sequence_number <= sq;
    in_reference_time <= ref_t;
    in_detection_time <= det;
    in_validity_present <= vp;
    in_validity_seconds <= vs;
    in_cause_code <= cc;
    in_current_time <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_table(cmd, st, sq, ref_t, det, vp, vs, cc, now);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d count %0d", out_status,
                   out_entry_count);
      end else begin
        outcome_t o;
        o = pending_outcomes.pop_front();
        if (out_status !== o.status || out_entry_count !== o.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected status %0d count %0d, got %0d %0d",
                     o.status, o.count, out_status, out_entry_count);
        end
      end
    end
  end

  task automatic receive_word(input logic [31:0] st, input logic [15:0] sq,
      input logic [41:0] ref_t, input logic [41:0] det, input logic vp,
      input logic [16:0] vs, input logic [7:0] cc);
    send_word(CMD_RECEIVE, st, sq, ref_t, det, vp, vs, cc, 42'($urandom));
  endtask

  task automatic test_directed;
    receive_word('0, '0, '0, '0, 1'b0, '0, 8'h00);
    receive_word('1, '1, '1, '1, 1'b1, 17'h1ffff, 8'hff);
    receive_word('1, '1, '1, 42'd5, 1'b1, 17'd86400, 8'h11);
    receive_word('1, '1, '1 - 1, 42'd5, 1'b1, 17'd3, 8'h11);
    receive_word('0, '0, 42'd9, 42'd1000, 1'b1, 17'd0, 8'h22);
    send_word(CMD_COUNT, '1, '1, '1, '1, 1'b1, '1, 8'hff, '1);
    send_word(CMD_COUNT, '0, '0, '0, '0, 1'b0, '0, 8'h22, '0);
    for (int i = 0; i < 16; i++)
      receive_word(32'h100 + i, 16'(i), 42'd1, 42'd0, 1'b1, 17'd1, 8'h33);
    send_word(CMD_COUNT, '0, '0, '0, '0, 1'b0, '0, 8'h33, '0);
    send_word(2'd3, '1, '1, '1, '1, 1'b1, '1, 8'hff, '1);
    send_word(CMD_DROP, '0, '0, '0, '0, 1'b0, '0, '0, 42'd1000);
    send_word(CMD_DROP, '0, '0, '0, '0, 1'b0, '0, '0, 42'd1001);
    send_word(CMD_DROP, '1, '1, '1, '1, 1'b1, '1, '1, '1);
  endtask

  task automatic test_random(input int items);
    for (int n = 0; n < items; n++) begin
      int k;
      int pick;
      logic [41:0] base;
      k = $urandom_range(7);
      pick = $urandom_range(99);
      base = 42'($urandom_range(2000000));
      idle_allowed = !(n >= items / 3 && n < items / 2);
      if (pick < 65) begin
        receive_word(($urandom_range(9) == 0) ? $urandom : key_stations[k],
                     ($urandom_range(9) == 0) ? 16'($urandom) : 16'(k),
                     ($urandom_range(15) == 0) ? rand42() : 42'($urandom_range(40)),
                     ($urandom_range(15) == 0) ? rand42() : base,
                     1'($urandom_range(1)),
                     17'($urandom_range(20) == 0 ? $urandom : $urandom_range(1500)),
                     8'($urandom_range(20) == 0 ? $urandom : $urandom_range(3)));
      end else if (pick < 82) begin
        send_word(CMD_DROP, $urandom, 16'($urandom), rand42(), rand42(),
                  1'($urandom_range(1)), 17'($urandom), 8'($urandom),
                  ($urandom_range(15) == 0) ? rand42() : 42'($urandom_range(3000000)));
      end else if (pick < 97) begin
        send_word(CMD_COUNT, $urandom, 16'($urandom), rand42(), rand42(),
                  1'($urandom_range(1)), 17'($urandom),
                  8'($urandom_range(20) == 0 ? $urandom : $urandom_range(3)),
                  rand42());
      end else begin
        send_word(2'd3, $urandom, 16'($urandom), rand42(), rand42(),
                  1'($urandom_range(1)), 17'($urandom), 8'($urandom), rand42());
      end
    end
    idle_allowed = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < 8; i++) key_stations[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(800);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
